// ----- sv/chov_pkg.sv -----
// ----------------------------------------------------------------------------
// chov_pkg
// Shared types and constants for the CoAP header and option validator.
// ----------------------------------------------------------------------------
package chov_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPTION_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 1'd1;

  localparam logic [15:0] LIMIT_RESET = 16'd1024;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FORMAT_ERR  = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_PAYLOAD_BIG = 2'd3
  } status_t;

  // parse phases
  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_TOKEN = 3'd1,
    PH_OPT   = 3'd2,
    PH_DEXT  = 3'd3,
    PH_LEXT  = 3'd4,
    PH_VAL   = 3'd5,
    PH_PAY   = 3'd6
  } phase_t;

  // reserved code classes
  localparam logic [2:0] CLS_RSV1 = 3'd1;
  localparam logic [2:0] CLS_RSV6 = 3'd6;
  localparam logic [2:0] CLS_RSV7 = 3'd7;

  // protocol constants
  localparam logic [1:0]  COAP_VERSION   = 2'b01;
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]  MAX_TKL        = 4'd8;
  localparam logic [3:0]  NIB_EXT8       = 4'd13;
  localparam logic [3:0]  NIB_EXT16      = 4'd14;
  localparam logic [3:0]  NIB_RESERVED   = 4'hF;
  localparam logic [16:0] EXT8_BASE      = 17'd13;
  localparam logic [16:0] EXT16_BASE     = 17'd269;
  localparam logic [15:0] POS_LIMIT      = 16'hFFFF;
  localparam logic [15:0] HDR_BYTES      = 16'd4;

endpackage

// ----- sv/chov_if.sv -----
// ----------------------------------------------------------------------------
// chov_in_if / chov_out_if
// Valid/ready channels for datagram bytes and validation results.
// ----------------------------------------------------------------------------
interface chov_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chov_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  mtype;
  logic [3:0]  token_length;
  logic [7:0]  code;
  logic [15:0] message_id;
  logic [7:0]  option_count;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;

  modport source (output valid, output status, output mtype, output token_length,
                  output code, output message_id, output option_count,
                  output payload_offset, output payload_length, input ready);
  modport sink   (input valid, input status, input mtype, input token_length,
                  input code, input message_id, input option_count,
                  input payload_offset, input payload_length, output ready);
endinterface

// ----- sv/coap_header_option_validator_top.sv -----
// The result is registered into the output register at the end of the last byte's transfer.
// Throughput: one datagram byte per cycle, set by the combinational per-byte parse step;
// a result that the sink has not yet taken holds off the next byte.
// Reset (synchronous, active low) returns the parser to header byte zero, clears the
// option count and error, and restores both length limits to 1024.
// ----------------------------------------------------------------------------
// coap_header_option_validator_top
// Byte-serial CoAP header check, token skip, option walk and payload sizing.
// ----------------------------------------------------------------------------
module coap_header_option_validator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  chov_in_if.sink                        in_s,
  chov_out_if.source                     out_s,
  input  logic                           cfg_we,
  input  logic [chov_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [chov_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import chov_pkg::*;

  // configuration registers
  logic [15:0] max_opt_r, max_pay_r;

  // parse state
  logic [15:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  status_t     err_r, err_nxt;
  logic [1:0]  mtype_r, mtype_nxt;
  logic [3:0]  tkl_r, tkl_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  optcnt_r, optcnt_nxt;
  logic [15:0] pstart_r, pstart_nxt;

  // result register
  logic        ovalid_r;
  status_t     ostatus_r, ostatus_nxt;
  logic [1:0]  omtype_r;
  logic [3:0]  otkl_r;
  logic [7:0]  ocode_r;
  logic [15:0] omid_r;
  logic [7:0]  ocnt_r;
  logic [15:0] opoff_r, opoff_nxt;
  logic [15:0] oplen_r, oplen_nxt;

  logic        xfer;
  logic [7:0]  b;
  logic        last;
  logic [15:0] total;
  logic [15:0] plen;
  logic [15:0] left_dec;
  logic        do_begin;
  logic [3:0]  begin_nib;
  logic        do_fin;
  logic [16:0] fin_len;
  logic [2:0]  cls;

  // handshake: the output register frees up as soon as the sink takes it
  assign in_s.ready = !ovalid_r || out_s.ready;
  assign xfer       = in_s.valid && in_s.ready;
  assign b          = in_s.data_byte;
  assign last       = in_s.last_byte;
  assign left_dec   = left_r - 16'd1;
  assign cls        = code_r[7:5];

  // per-byte parse step
  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    err_nxt     = err_r;
    mtype_nxt   = mtype_r;
    tkl_nxt     = tkl_r;
    code_nxt    = code_r;
    mid_nxt     = mid_r;
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    left_nxt    = left_r;
    optcnt_nxt  = optcnt_r;
    pstart_nxt  = pstart_r;
    total       = pos_r;
    do_begin    = 1'b0;
    begin_nib   = pend_r;
    do_fin      = 1'b0;
    fin_len     = 17'd0;
    ostatus_nxt = ST_OK;
    opoff_nxt   = 16'd0;
    oplen_nxt   = 16'd0;
    plen        = 16'd0;

    if (xfer) begin
      if (pos_r == POS_LIMIT) begin
        // overlong datagram
        if (err_r == ST_OK) err_nxt = ST_FORMAT_ERR;
        total = POS_LIMIT;
      end else begin
        // latch header bytes even after an error
        case (pos_r)
          16'd0: begin
            mtype_nxt = b[5:4];
            tkl_nxt   = b[3:0];
            code_nxt  = 8'd0;
            mid_nxt   = 16'd0;
          end
          16'd1: code_nxt = b;
          16'd2: mid_nxt = {b, 8'd0};
          16'd3: mid_nxt = {mid_r[15:8], b};
          default: ;
        endcase
        pos_nxt = pos_r + 16'd1;
        total   = pos_r + 16'd1;

        if (err_r == ST_OK) begin
          case (phase_r)
            PH_HDR: begin
              if (pos_r == 16'd0) begin
                if (b[7:6] != COAP_VERSION) err_nxt = ST_BAD_VERSION;
                else if (b[3:0] > MAX_TKL) err_nxt = ST_FORMAT_ERR;
              end else if (pos_r == 16'd3) begin
                if (code_r == 8'd0 && (tkl_r != 4'd0 || !last)) err_nxt = ST_FORMAT_ERR;
                else if (cls inside {CLS_RSV1, CLS_RSV6, CLS_RSV7}) err_nxt = ST_FORMAT_ERR;
                else if (tkl_r != 4'd0) begin
                  left_nxt  = {12'd0, tkl_r};
                  phase_nxt = PH_TOKEN;
                end else begin
                  phase_nxt = PH_OPT;
                end
              end
            end
            PH_TOKEN, PH_VAL: begin
              left_nxt = left_dec;
              if (left_dec == 16'd0) phase_nxt = PH_OPT;
            end
            PH_OPT: begin
              if (b == PAYLOAD_MARKER) begin
                pstart_nxt = pos_r + 16'd1;
                phase_nxt  = PH_PAY;
              end else if (b[7:4] == NIB_RESERVED || b[3:0] == NIB_RESERVED) begin
                err_nxt = ST_FORMAT_ERR;
              end else begin
                pend_nxt = b[3:0];
                if (b[7:4] == NIB_EXT8 || b[7:4] == NIB_EXT16) begin
                  left_nxt  = (b[7:4] == NIB_EXT8) ? 16'd1 : 16'd2;
                  phase_nxt = PH_DEXT;
                end else begin
                  do_begin  = 1'b1;
                  begin_nib = b[3:0];
                end
              end
            end
            PH_DEXT: begin
              left_nxt = left_dec;
              if (left_dec == 16'd0) do_begin = 1'b1;
            end
            PH_LEXT: begin
              acc_nxt  = {acc_r[7:0], b};
              left_nxt = left_dec;
              if (left_dec == 16'd0) begin
                do_fin  = 1'b1;
                fin_len = {1'b0, acc_r[7:0], b}
                          + ((pend_r == NIB_EXT8) ? EXT8_BASE : EXT16_BASE);
              end
            end
            default: ;
          endcase

          // start of the option length
          if (do_begin) begin
            if (begin_nib == NIB_EXT8 || begin_nib == NIB_EXT16) begin
              left_nxt  = (begin_nib == NIB_EXT8) ? 16'd1 : 16'd2;
              acc_nxt   = 16'd0;
              phase_nxt = PH_LEXT;
            end else begin
              do_fin  = 1'b1;
              fin_len = {13'd0, begin_nib};
            end
          end

          // option length known: check limit and count
          if (do_fin) begin
            if (fin_len > {1'b0, max_opt_r}) begin
              err_nxt = ST_FORMAT_ERR;
            end else begin
              if (optcnt_r != 8'hFF) optcnt_nxt = optcnt_r + 8'd1;
              if (fin_len == 17'd0) begin
                phase_nxt = PH_OPT;
              end else begin
                left_nxt  = fin_len[15:0];
                phase_nxt = PH_VAL;
              end
            end
          end
        end
      end

      // final byte: form the result and rearm for the next datagram
      if (last) begin
        plen = total - pstart_nxt;
        if (total < HDR_BYTES) begin
          ostatus_nxt = ST_FORMAT_ERR;
        end else if (err_nxt != ST_OK) begin
          ostatus_nxt = err_nxt;
        end else if (phase_nxt == PH_OPT) begin
          ostatus_nxt = ST_OK;
        end else if (phase_nxt == PH_PAY) begin
          if (plen == 16'd0) begin
            ostatus_nxt = ST_FORMAT_ERR;
          end else begin
            ostatus_nxt = (plen > max_pay_r) ? ST_PAYLOAD_BIG : ST_OK;
            opoff_nxt   = pstart_nxt;
            oplen_nxt   = plen;
          end
        end else begin
          ostatus_nxt = ST_FORMAT_ERR;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_opt_r <= LIMIT_RESET;
      max_pay_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_OPTION_LEN:  max_opt_r <= cfg_wdata;
        CFG_MAX_PAYLOAD_LEN: max_pay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n || (xfer && last)) begin
      pos_r    <= 16'd0;
      phase_r  <= PH_HDR;
      err_r    <= ST_OK;
      mtype_r  <= 2'd0;
      tkl_r    <= 4'd0;
      code_r   <= 8'd0;
      mid_r    <= 16'd0;
      acc_r    <= 16'd0;
      pend_r   <= 4'd0;
      left_r   <= 16'd0;
      optcnt_r <= 8'd0;
      pstart_r <= 16'd0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      err_r    <= err_nxt;
      mtype_r  <= mtype_nxt;
      tkl_r    <= tkl_nxt;
      code_r   <= code_nxt;
      mid_r    <= mid_nxt;
      acc_r    <= acc_nxt;
      pend_r   <= pend_nxt;
      left_r   <= left_nxt;
      optcnt_r <= optcnt_nxt;
      pstart_r <= pstart_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (xfer && last) begin
      ovalid_r <= 1'b1;
    end else if (out_s.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (xfer && last) begin
      ostatus_r <= ostatus_nxt;
      omtype_r  <= mtype_nxt;
      otkl_r    <= tkl_nxt;
      ocode_r   <= code_nxt;
      omid_r    <= mid_nxt;
      ocnt_r    <= optcnt_nxt;
      opoff_r   <= opoff_nxt;
      oplen_r   <= oplen_nxt;
    end
  end

  assign out_s.valid          = ovalid_r;
  assign out_s.status         = ostatus_r;
  assign out_s.mtype          = omtype_r;
  assign out_s.token_length   = otkl_r;
  assign out_s.code           = ocode_r;
  assign out_s.message_id     = omid_r;
  assign out_s.option_count   = ocnt_r;
  assign out_s.payload_offset = opoff_r;
  assign out_s.payload_length = oplen_r;

endmodule
